FILE: sv/midi_track_event_parser_top_assert.svh
// ---------------------------------------------------------------------------
// midi track event parser assertion macros
// shared concurrent assertion wrappers, clocked on clk; MTEP_ASSERT is disabled by rst, MTEP_ASSERT_ALWAYS is not
// ---------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTEP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mtep assertion failed");
`define MTEP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mtep assertion failed");
`else
`define MTEP_ASSERT(label, prop)
`define MTEP_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: sv/mtep_pkg.sv
// ---------------------------------------------------------------------------
// mtep_pkg
// types and constants shared by the midi track event parser
// ---------------------------------------------------------------------------
`default_nettype none
package mtep_pkg;
  localparam int TICK_W = 32;
  localparam int NOTE_W = 7;
  localparam int CH_W   = 4;
  localparam int ADDR_W = CH_W + NOTE_W;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_META_TYPE = 4'd2;
  localparam logic [3:0] PH_META_LEN  = 4'd3;
  localparam logic [3:0] PH_SYSEX_LEN = 4'd4;
  localparam logic [3:0] PH_SKIP      = 4'd5;
  localparam logic [3:0] PH_TEMPO     = 4'd6;
  localparam logic [3:0] PH_DATA1     = 4'd7;
  localparam logic [3:0] PH_DATA2     = 4'd8;

  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [31:0] TEMPO_LEN  = 32'd3;
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_PROGRAM  = 4'hC;
  localparam logic [3:0] MSG_PRESSURE = 4'hD;

  localparam logic KIND_NOTE  = 1'b0;
  localparam logic KIND_TEMPO = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] start;
    logic [6:0]        vel;
    logic [6:0]        prog;
  } entry_t;

  typedef struct packed {
    logic              note_en;
    logic              note_off;
    logic [ADDR_W-1:0] idx;
    logic [TICK_W-1:0] tick;
    logic [6:0]        vel;
    logic [6:0]        prog;
    logic              tempo_en;
    logic [23:0]       tempo;
  } event_t;

  typedef struct packed {
    logic [6:0]        pad;
    logic [23:0]       tempo_us;
    logic [6:0]        program_number;
    logic [3:0]        channel_index;
    logic [6:0]        note_velocity;
    logic [6:0]        note_number;
    logic [TICK_W-1:0] tick_off;
    logic [TICK_W-1:0] tick_on;
  } out_data_t;
endpackage
`default_nettype wire

FILE: sv/mtep_parser.sv
// ---------------------------------------------------------------------------
// mtep_parser
// byte-level track parser: delta times, running status, skipping, events
// ---------------------------------------------------------------------------
`default_nettype none
module mtep_parser import mtep_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       new_track,
  input  wire logic       file_start,
  output event_t          ev
);
  logic [3:0]        phase, p;
  logic [TICK_W-1:0] tick, t;
  logic [31:0]       vlq, v, acc7;
  logic [7:0]        rs, r;
  logic [7:0]        meta, m;
  logic [31:0]       skip, s;
  logic [23:0]       held, h;
  logic [6:0]        progs [16];
  logic              prog_wr;
  logic              is_meta;

  always_comb begin
    p = phase; t = tick; v = vlq; r = rs; m = meta; s = skip; h = held;
    prog_wr = 1'b0;
    is_meta = 1'b0;
    ev = '0;
    if (new_track || file_start) begin
      p = PH_DELTA; t = '0; v = '0; r = '0; m = '0; s = '0; h = '0;
    end
    acc7 = {v[24:0], data_byte[6:0]};
    case (p)
      PH_DELTA: begin
        v = acc7;
        if (!data_byte[7]) begin
          t = t + acc7;
          v = '0;
          p = PH_STATUS;
        end
      end
      PH_STATUS, PH_DATA1: begin
        if (p == PH_STATUS && data_byte[7]) begin
          if (data_byte == ST_META) begin
            r = '0;
            p = PH_META_TYPE;
          end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_CONT) begin
            r = '0;
            v = '0;
            p = PH_SYSEX_LEN;
          end else begin
            r = data_byte;
            p = PH_DATA1;
          end
        end else begin
          h = {17'd0, data_byte[6:0]};
          if (r[7:4] == MSG_PROGRAM || r[7:4] == MSG_PRESSURE) begin
            prog_wr = (r[7:4] == MSG_PROGRAM);
            p = PH_DELTA;
          end else begin
            p = PH_DATA2;
          end
        end
      end
      PH_META_TYPE: begin
        m = data_byte;
        v = '0;
        p = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        is_meta = (p == PH_META_LEN);
        v = acc7;
        if (!data_byte[7]) begin
          v = '0;
          s = acc7;
          h = '0;
          if (acc7 == '0) p = PH_DELTA;
          else if (is_meta && m == META_TEMPO && acc7 == TEMPO_LEN) p = PH_TEMPO;
          else p = PH_SKIP;
        end
      end
      PH_SKIP: begin
        s = s - 32'd1;
        if (s == '0) p = PH_DELTA;
      end
      PH_TEMPO: begin
        h = {h[15:0], data_byte};
        s = s - 32'd1;
        if (s == '0) begin
          p = PH_DELTA;
          ev.tempo_en = 1'b1;
          ev.tempo = h;
          ev.tick = t;
        end
      end
      PH_DATA2: begin
        p = PH_DELTA;
        if (r[7:4] == MSG_NOTE_OFF || r[7:4] == MSG_NOTE_ON) begin
          ev.note_en  = 1'b1;
          ev.note_off = (r[7:4] == MSG_NOTE_OFF) || (data_byte[6:0] == 7'd0);
          ev.idx      = {r[3:0], h[6:0]};
          ev.tick     = t;
          ev.vel      = data_byte[6:0];
          ev.prog     = progs[r[3:0]];
        end
      end
      default: p = PH_DELTA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DELTA; tick <= '0; vlq <= '0; rs <= '0;
      meta <= '0; skip <= '0; held <= '0;
      for (int i = 0; i < 16; i++) progs[i] <= '0;
    end else if (accept) begin
      phase <= p; tick <= t; vlq <= v; rs <= r;
      meta <= m; skip <= s; held <= h;
      if (file_start) begin
        for (int i = 0; i < 16; i++) progs[i] <= '0;
      end else if (prog_wr) begin
        progs[r[3:0]] <= h[6:0];
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/mtep_note_table.sv
// ---------------------------------------------------------------------------
// mtep_note_table
// active note memory, one entry per channel and note, with clearing sweep
// ---------------------------------------------------------------------------
`default_nettype none
module mtep_note_table import mtep_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear_start,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  output logic                   busy
);
  entry_t            mem [DEPTH];
  logic [ADDR_W-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      sweep_addr <= '0;
    end else if (clear_start) begin
      busy <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      sweep_addr <= sweep_addr + ADDR_W'(1);
      if (sweep_addr == ADDR_W'(DEPTH - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) mem[sweep_addr] <= '0;
    else if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: sv/midi_track_event_parser_top.sv
// ---------------------------------------------------------------------------
// midi_track_event_parser_top
// standard midi track byte parser producing note and tempo records
// ---------------------------------------------------------------------------
// a record reaches the master side after the beat that completes it passes the stage-one
// register and the note table read (on the accepting edge), then the output register
// throughput: one byte per cycle while s_tready is high; the note table is read once
// per note event; reset and every track or file start run a clearing sweep over all
// 2048 note table entries, during which s_tready stays low
`default_nettype none
`include "midi_track_event_parser_top_assert.svh"
module midi_track_event_parser_top import mtep_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // data_byte
  input  wire logic [1:0]   s_tuser,   // new track flag, file_start
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [119:0]      m_tdata,   // note on tick, note off tick, note_number,
                                       // note_velocity, channel_index,
                                       // program_number, tempo_us, zero pad
  output logic [0:0]        m_tuser    // record_kind
);
  logic      accept;
  event_t    ev;
  // stage one: event waiting on the note table read
  logic      s1_valid;
  event_t    s1_ev;
  entry_t    rd_data;
  entry_t    wr_data;
  logic      wr_en;
  logic      busy;
  logic      s1_result;
  logic      s1_stall;
  logic      out_free;
  out_data_t rec;

  assign accept = s_tvalid && s_tready;

  mtep_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .new_track   (s_tuser[0]),
    .file_start  (s_tuser[1]),
    .ev          (ev)
  );

  // note lookups are at least three beats apart, so a write back never
  // overlaps the next read of the same entry
  mtep_note_table u_table (
    .clk         (clk),
    .rst         (rst),
    .clear_start (accept && (s_tuser[0] || s_tuser[1])),
    .rd_en       (accept && ev.note_en),
    .rd_addr     (ev.idx),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (s1_ev.idx),
    .wr_data     (wr_data),
    .busy        (busy)
  );

  // a note off only yields a record when the entry is live
  assign s1_result = s1_valid && (s1_ev.tempo_en ||
                     (s1_ev.note_en && s1_ev.note_off && rd_data.valid));
  assign out_free  = !m_tvalid || m_tready;
  assign s1_stall  = s1_result && !out_free;
  assign s_tready  = !busy && !s1_stall;

  always_comb begin
    wr_en   = s1_valid && !s1_stall && s1_ev.note_en;
    wr_data = '0;
    if (!s1_ev.note_off) begin
      wr_data.valid = 1'b1;
      wr_data.start = s1_ev.tick;
      wr_data.vel   = s1_ev.vel;
      wr_data.prog  = s1_ev.prog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid <= accept && (ev.note_en || ev.tempo_en);
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_stall) s1_ev <= ev;
  end

  // output record assembly
  always_comb begin
    rec = '0;
    if (s1_ev.tempo_en) begin
      rec.tick_on  = s1_ev.tick;
      rec.tempo_us = s1_ev.tempo;
    end else begin
      rec.tick_on        = rd_data.start;
      rec.tick_off       = s1_ev.tick;
      rec.note_number    = s1_ev.idx[NOTE_W-1:0];
      rec.note_velocity  = rd_data.vel;
      rec.channel_index  = s1_ev.idx[ADDR_W-1:NOTE_W];
      rec.program_number = rd_data.prog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_result) begin
      m_tdata <= rec;
      m_tuser <= s1_ev.tempo_en ? KIND_TEMPO : KIND_NOTE;
    end
  end

  // no beat is taken during the clearing sweep
  `MTEP_ASSERT(a_no_accept_busy, busy |-> !accept)
  // a track or file start always launches a sweep
  `MTEP_ASSERT(a_start_sweeps, (accept && (s_tuser[0] || s_tuser[1])) |=> busy)
  // note lookups never come on consecutive beats
  `MTEP_ASSERT(a_lookup_spacing, (accept && ev.note_en) |=> !(accept && ev.note_en))
  // tempo records carry a zero end tick
  `MTEP_ASSERT(a_tempo_end_zero, (m_tvalid && m_tuser[0] == KIND_TEMPO) |-> (m_tdata[63:32] == '0))
  // no table write during a sweep
  `MTEP_ASSERT_ALWAYS(a_no_write_busy, (!rst && busy) |-> !wr_en)
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// midi track event parser testbench
// streams standard midi track bytes into the parser and checks every note
// and tempo record against a cycle-free predictor kept inside the bench
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
  import mtep_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic [1:0]   s_tuser = 2'b00;   // new track flag, file_start
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;           // note on tick .. tempo_us, zero pad
  logic [0:0]   m_tuser;           // record_kind

  midi_track_event_parser_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // ------------------------------------------------------------------------
  // predictor state: one copy of the parser's track and file state
  // ------------------------------------------------------------------------
  typedef struct {
    logic      kind;
    out_data_t rec;
  } record_t;

  record_t     pending_records[$];
  logic [3:0]  pr_phase;
  logic [31:0] pr_tick, pr_vlq, pr_skip;
  logic [7:0]  pr_status, pr_meta;
  logic [23:0] pr_held;
  logic [6:0]  pr_prog [16];
  logic        nt_valid [DEPTH];
  logic [31:0] nt_start [DEPTH];
  logic [6:0]  nt_vel [DEPTH];
  logic [6:0]  nt_prog [DEPTH];

  int errors = 0;
  int beats_sent = 0;
  int records_seen = 0;
  int tempo_seen = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;
  logic next_track = 1'b0;
  logic next_file = 1'b0;

  function automatic void clear_track_state();
    pr_phase = PH_DELTA;
    pr_tick = '0;
    pr_vlq = '0;
    pr_status = '0;
    pr_meta = '0;
    pr_skip = '0;
    pr_held = '0;
    for (int i = 0; i < DEPTH; i++) begin
      nt_valid[i] = 1'b0;
    end
  endfunction

  // a program change or channel pressure takes one data byte, the rest two
  function automatic logic single_data(input logic [7:0] st);
    return st[7:4] == MSG_PROGRAM || st[7:4] == MSG_PRESSURE;
  endfunction

  function automatic void finish_first_data(input logic [7:0] b);
    pr_held = {17'd0, b[6:0]};
    if (single_data(pr_status)) begin
      if (pr_status[7:4] == MSG_PROGRAM) pr_prog[pr_status[3:0]] = b[6:0];
      pr_phase = PH_DELTA;
    end else begin
      pr_phase = PH_DATA2;
    end
  endfunction

  // advance the predicted parser by one accepted byte
  function automatic void parse_byte(input logic [7:0] b, input logic ts, input logic fs);
    record_t r;
    logic [31:0] acc;
    logic [ADDR_W-1:0] idx;
    r.kind = KIND_NOTE;
    r.rec = '0;
    if (fs) begin
      clear_track_state();
      for (int c = 0; c < 16; c++) pr_prog[c] = '0;
    end else if (ts) begin
      clear_track_state();
    end
    case (pr_phase)
      PH_DELTA: begin
        pr_vlq = {pr_vlq[24:0], b[6:0]};
        if (!b[7]) begin
          pr_tick = pr_tick + pr_vlq;
          pr_vlq = '0;
          pr_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          if (b == ST_META) begin
            pr_status = '0;
            pr_phase = PH_META_TYPE;
          end else if (b == ST_SYSEX || b == ST_SYSEX_CONT) begin
            pr_status = '0;
            pr_vlq = '0;
            pr_phase = PH_SYSEX_LEN;
          end else begin
            pr_status = b;
            pr_phase = PH_DATA1;
          end
        end else begin
          // running status: this byte is already the first data byte
          finish_first_data(b);
        end
      end
      PH_META_TYPE: begin
        pr_meta = b;
        pr_vlq = '0;
        pr_phase = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        pr_vlq = {pr_vlq[24:0], b[6:0]};
        if (!b[7]) begin
          acc = pr_vlq;
          pr_vlq = '0;
          pr_skip = acc;
          pr_held = '0;
          if (acc == 0) pr_phase = PH_DELTA;
          else if (pr_phase == PH_META_LEN && pr_meta == META_TEMPO && acc == TEMPO_LEN)
            pr_phase = PH_TEMPO;
          else pr_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        pr_skip = pr_skip - 1;
        if (pr_skip == 0) pr_phase = PH_DELTA;
      end
      PH_TEMPO: begin
        pr_held = {pr_held[15:0], b};
        pr_skip = pr_skip - 1;
        if (pr_skip == 0) begin
          pr_phase = PH_DELTA;
          r.kind = KIND_TEMPO;
          r.rec.tick_on = pr_tick;
          r.rec.tempo_us = pr_held;
          pending_records.insert(pending_records.size(), r);
        end
      end
      PH_DATA1: finish_first_data(b);
      PH_DATA2: begin
        pr_phase = PH_DELTA;
        idx = {pr_status[3:0], pr_held[6:0]};
        if (pr_status[7:4] == MSG_NOTE_OFF || pr_status[7:4] == MSG_NOTE_ON) begin
          if (pr_status[7:4] == MSG_NOTE_OFF || b[6:0] == 0) begin
            // unmatched note off falls through silently
            if (nt_valid[idx]) begin
              nt_valid[idx] = 1'b0;
              r.rec.tick_on = nt_start[idx];
              r.rec.tick_off = pr_tick;
              r.rec.note_number = pr_held[6:0];
              r.rec.note_velocity = nt_vel[idx];
              r.rec.channel_index = pr_status[3:0];
              r.rec.program_number = nt_prog[idx];
              pending_records.insert(pending_records.size(), r);
            end
          end else begin
            // a repeated note on just overwrites the entry
            nt_valid[idx] = 1'b1;
            nt_start[idx] = pr_tick;
            nt_vel[idx] = b[6:0];
            nt_prog[idx] = pr_prog[pr_status[3:0]];
          end
        end
      end
      default: pr_phase = PH_DELTA;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // result side: random stalls, long hold-offs, field by field compare
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    record_t   want;
    out_data_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        records_seen++;
        if (pending_records.size() == 0) begin
          $error("record with none expected: kind %0d tdata %h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = pending_records.pop_front();
          if (want.kind == KIND_TEMPO) tempo_seen++;
          if (m_tuser[0] !== want.kind) begin
            $error("record_kind: expected %0d, got %0d", want.kind, m_tuser[0]);
            errors++;
          end
          if (got.tick_on !== want.rec.tick_on) begin
            $error("tick_on: expected %0d, got %0d", want.rec.tick_on, got.tick_on);
            errors++;
          end
          if (got.tick_off !== want.rec.tick_off) begin
            $error("tick_off: expected %0d, got %0d", want.rec.tick_off, got.tick_off);
            errors++;
          end
          if (got.note_number !== want.rec.note_number) begin
            $error("note_number: expected %0d, got %0d", want.rec.note_number,
                   got.note_number);
            errors++;
          end
          if (got.note_velocity !== want.rec.note_velocity) begin
            $error("note_velocity: expected %0d, got %0d", want.rec.note_velocity,
                   got.note_velocity);
            errors++;
          end
          if (got.channel_index !== want.rec.channel_index) begin
            $error("channel_index: expected %0d, got %0d", want.rec.channel_index,
                   got.channel_index);
            errors++;
          end
          if (got.program_number !== want.rec.program_number) begin
            $error("program_number: expected %0d, got %0d", want.rec.program_number,
                   got.program_number);
            errors++;
          end
          if (got.tempo_us !== want.rec.tempo_us) begin
            $error("tempo_us: expected %0d, got %0d", want.rec.tempo_us, got.tempo_us);
            errors++;
          end
        end
      end
      // a pending hold-off beats the random stall pattern
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------------
  // byte sender and event builders
  // ------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= {next_file, next_track};
    do @(posedge clk); while (!s_tready);
    parse_byte(b, next_track, next_file);
    next_track = 1'b0;
    next_file = 1'b0;
    beats_sent++;
  endtask

  // variable-length quantity, nbytes groups of 7 bits, high group first
  task automatic send_vlq(input logic [34:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      send_beat({i != 0, v[7*i +: 7]});
    end
  endtask

  task automatic send_delta();
    int r;
    r = $urandom_range(99);
    if (r < 60) send_vlq(35'($urandom_range(127)), 1);
    else if (r < 85) send_vlq(35'($urandom_range(16383)), 2);
    else if (r < 95) send_vlq(35'($urandom), 4);
    else send_vlq({$urandom, 3'($urandom)}, 5);   // may overflow the 32-bit sum
  endtask

  // open notes kept by the generator so note offs usually match
  logic [10:0] open_notes[$];
  logic [7:0]  last_status = 8'h00;

  task automatic send_channel(input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2,
                              input logic two);
    if (st == last_status && $urandom_range(2) == 0) begin
      // running status, status byte left out
    end else begin
      send_beat(st);
    end
    last_status = st;
    send_beat(d1);
    if (two) send_beat(d2);
  endtask

  task automatic random_event();
    int r, k, n;
    logic [3:0] ch;
    logic [7:0] nn;
    r = $urandom_range(99);
    ch = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(3));
    nn = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(60, 67));
    send_delta();
    if (r < 38) begin
      send_channel({MSG_NOTE_ON, ch}, nn, 8'($urandom_range(1, 255)), 1'b1);
      open_notes.insert(open_notes.size(), {ch, nn[6:0]});
    end else if (r < 68) begin
      if (open_notes.size() > 0) begin
        k = $urandom_range(open_notes.size() - 1);
        ch = open_notes[k][10:7];
        nn = {1'b0, open_notes[k][6:0]};
        open_notes.delete(k);
      end
      if ($urandom_range(1)) send_channel({MSG_NOTE_OFF, ch}, nn, 8'($urandom), 1'b1);
      else send_channel({MSG_NOTE_ON, ch}, nn, ($urandom_range(1) ? 8'h80 : 8'h00), 1'b1);
    end else if (r < 76) begin
      send_channel({($urandom_range(1) ? MSG_PROGRAM : MSG_PRESSURE), ch}, 8'($urandom),
                   8'h00, 1'b0);
    end else if (r < 83) begin
      send_beat(ST_META); send_beat(META_TEMPO); send_beat(8'h03);
      repeat (3) send_beat(8'($urandom));
      last_status = 8'h00;
    end else if (r < 89) begin
      n = $urandom_range(4);
      if ($urandom_range(1)) begin
        send_beat(ST_META);
        send_beat($urandom_range(1) ? META_TEMPO : 8'($urandom));
      end else begin
        send_beat($urandom_range(1) ? ST_SYSEX : ST_SYSEX_CONT);
      end
      send_vlq(35'(n), 1);
      repeat (n) send_beat(8'($urandom));
      last_status = 8'h00;
    end else if (r < 93) begin
      send_channel($urandom_range(1) ? {4'($urandom_range(10, 11)), ch} : 8'($urandom_range(241, 254)),
                   8'($urandom), 8'($urandom), 1'b1);
    end else if (r < 97) begin
      send_beat(8'($urandom));   // loose byte, parser picks it up wherever it is
    end else begin
      // cut an event short; the next track start drops it
      send_beat({MSG_NOTE_ON, ch});
      if ($urandom_range(1)) send_beat(nn);
      next_track = 1'b1;
      next_file = ($urandom_range(3) == 0);
      open_notes.delete();
      last_status = 8'h00;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_directed();
    src_idle_pct = 0; snk_stall_pct = 0;
    next_file = 1'b1; next_track = 1'b1;
    send_vlq(35'd0, 1);
    send_beat({MSG_PROGRAM, 4'h3}); send_beat(8'hFF);        // program 127, top bit dropped
    send_vlq(35'd0, 1);
    send_beat({MSG_NOTE_ON, 4'h3}); send_beat(8'hBC); send_beat(8'hFF);
    send_vlq(35'h0FFF_FFFF, 4);                              // longest legal delta
    send_beat(8'h3C); send_beat(8'h00);                      // running status, vel 0 ends it
    send_vlq(35'd1, 1);
    send_beat({MSG_NOTE_OFF, 4'h3}); send_beat(8'h3C); send_beat(8'h40); // unmatched off
    send_vlq(35'd0, 1);
    send_beat({MSG_NOTE_ON, 4'hF}); send_beat(8'h7F); send_beat(8'h01);
    send_vlq(35'd0, 1);
    send_beat(8'h7F); send_beat(8'h05);                      // repeated note on overwrites
    send_vlq(35'h7_FFFF_FFFF, 5);                            // accumulator overflow
    send_beat({MSG_NOTE_OFF, 4'hF}); send_beat(8'h7F); send_beat(8'h00);
    send_vlq(35'd0, 1);
    send_beat(ST_META); send_beat(META_TEMPO); send_beat(8'h03);
    send_beat(8'hFF); send_beat(8'hFF); send_beat(8'hFF);   // largest tempo
    send_vlq(35'd0, 1);
    send_beat(ST_META); send_beat(META_TEMPO); send_beat(8'h04);
    repeat (4) send_beat(8'h00);                             // wrong length is skipped
    send_vlq(35'd0, 1);
    send_beat(ST_META); send_beat(8'h2F); send_beat(8'h00);  // empty meta
    send_vlq(35'd0, 1);
    send_beat(ST_SYSEX); send_beat(8'h02); send_beat(8'h11); send_beat(8'hF7);
    send_vlq(35'd0, 1);
    send_beat(ST_SYSEX_CONT); send_beat(8'h00);
    send_vlq(35'd0, 1);
    send_beat(8'h45); send_beat(8'h46);                      // data with no running status
    send_vlq(35'd0, 1);
    send_beat(8'hF2); send_beat(8'h01); send_beat(8'h02);
    send_vlq(35'd0, 1);
    send_beat({MSG_NOTE_ON, 4'h0}); send_beat(8'h00);        // truncated by track start
    next_track = 1'b1;
    send_vlq(35'd0, 1);
    send_beat(ST_META); send_beat(META_TEMPO); send_beat(8'h03);
    send_beat(8'h00); send_beat(8'h00); send_beat(8'h00);   // zero tempo
    wait_drained();
  endtask

  task automatic test_random(input int idle, input int stall, input int n);
    int start_beats;
    src_idle_pct = idle; snk_stall_pct = stall;
    start_beats = beats_sent;
    while (beats_sent - start_beats < n) random_event();
    wait_drained();
  endtask

  // receiver holds off long enough for the parser to back up its input
  task automatic test_backpressure();
    int start_beats;
    src_idle_pct = 0; snk_stall_pct = 0;
    hold_cycles = 400;
    start_beats = beats_sent;
    while (beats_sent - start_beats < 120) begin
      send_delta();
      send_channel({MSG_NOTE_ON, 4'h1}, 8'h30, 8'h20, 1'b1);
      send_vlq(35'd3, 1);
      send_channel({MSG_NOTE_OFF, 4'h1}, 8'h30, 8'h00, 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 200);
    test_random(75, 0, 200);
    test_random(0, 75, 200);
    test_random(35, 35, 200);
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d beats, checked %0d records (%0d tempo) across idle and stall phases",
             beats_sent, records_seen, tempo_seen);
    $display("covered running status, vlq overflow, skipped events and track restarts");
    if (errors == 0 && pending_records.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d records outstanding", pending_records.size());
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/mtep_pkg.sv
sv/mtep_parser.sv
sv/mtep_note_table.sv
sv/midi_track_event_parser_top.sv
tb/testbench.sv
